// ===== rtl/core/mspt_pkg.sv =====
// Package for the multi-slot periodic timer.
// Holds request and response codes, state encoding and slot record types.
// No dependencies.
package mspt_pkg;

    localparam int unsigned MAX_OUT = 8;
    localparam int unsigned CNT_W   = 4;

    localparam logic [7:0] FOREVER   = 8'd255;
    localparam logic [7:0] FULL_SLOT = 8'd255;

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_RESTART = 3'd1,
        REQ_CANCEL  = 3'd2,
        REQ_TICK    = 3'd3,
        REQ_POLL    = 3'd4
    } t_req_type;

    typedef enum logic [2:0] {
        RESP_START   = 3'd0,
        RESP_RESTART = 3'd1,
        RESP_CANCEL  = 3'd2,
        RESP_TICK    = 3'd3,
        RESP_EXPIRY  = 3'd4,
        RESP_NONE    = 3'd5
    } t_resp_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_POLL = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] period;
        logic [7:0]  repeats;
    } t_timing;

    typedef struct packed {
        logic        tim_we;
        logic        tag_we;
        logic [7:0]  addr;
        t_timing     tim;
        logic [15:0] tag;
    } t_wr_cmd;

    typedef struct packed {
        t_resp_kind  kind;
        logic        ok;
        logic [7:0]  slot;
        logic [15:0] tag;
        logic        last;
    } t_result;

endpackage

// ===== rtl/core/mspt_req_if.sv =====
// Request channel of the multi-slot periodic timer.
// Carries valid, ready and the request fields; no dependencies.
interface mspt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  slot_id;
    logic [31:0] period_ms;
    logic [7:0]  repeat_count;
    logic [15:0] user_tag;

    modport source (output valid, req_type, slot_id, period_ms, repeat_count, user_tag,
                    input ready);
    modport sink   (input valid, req_type, slot_id, period_ms, repeat_count, user_tag,
                    output ready);
endinterface

// ===== rtl/core/mspt_resp_if.sv =====
// Response channel of the multi-slot periodic timer.
// Carries valid, ready and the response fields; no dependencies.
interface mspt_resp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  resp_kind;
    logic        ok;
    logic [7:0]  slot_out;
    logic [15:0] tag_out;
    logic        last;

    modport source (output valid, resp_kind, ok, slot_out, tag_out, last, input ready);
    modport sink   (input valid, resp_kind, ok, slot_out, tag_out, last, output ready);
endinterface

// ===== rtl/core/multi_slot_periodic_timer.sv =====
// Multi-slot periodic timer: start, restart, cancel, tick and poll over a slot table.
// Start, restart, cancel and tick answer in the next cycle; outside a poll, one request per
// cycle is taken while the response side keeps up. A poll reads one slot per cycle from the
// slot memory while no expiry waits on a stalled response, and ends with the final response.
// Reset is synchronous: the tick counter is zero and all slots are free at once.
// Uses mspt_pkg, mspt_req_if, mspt_resp_if and mspt_slot_store.
module multi_slot_periodic_timer #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mspt_req_if.sink    i_req,
    mspt_resp_if.source o_resp
);
    localparam int AW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

    mspt_pkg::t_state    r_state, n_state;
    logic [31:0]         r_now, n_now;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic [AW-1:0]       r_idx, n_idx;
    logic [mspt_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                r_pend_vld, n_pend_vld;
    logic [AW-1:0]       r_pend_slot, n_pend_slot;
    logic [15:0]         r_pend_tag, n_pend_tag;
    logic                r_out_vld, n_out_vld;
    mspt_pkg::t_result   r_out, n_out;

    mspt_pkg::t_wr_cmd   wr;
    logic [AW-1:0]       raddr;
    mspt_pkg::t_timing   rd_tim;
    logic [15:0]         rd_tag;

    logic                out_free;
    logic                req_acc;
    logic [31:0]         elapsed;
    logic                due;
    logic                ev_stall;
    logic                scan_end;
    logic [AW-1:0]       sid_idx;
    logic                sid_valid;
    logic                has_free;
    logic [AW-1:0]       free_idx;
    logic [7:0]          new_rep;

    mspt_slot_store #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_tim   (rd_tim),
        .o_tag   (rd_tag)
    );

    assign out_free     = !r_out_vld || o_resp.ready;
    assign i_req.ready  = (r_state == mspt_pkg::S_IDLE) && out_free;
    assign req_acc      = i_req.valid && i_req.ready;

    assign elapsed  = r_now - rd_tim.start;
    assign due      = r_active[r_idx] && (elapsed >= rd_tim.period);
    assign ev_stall = due && r_pend_vld && !out_free;
    assign scan_end = (r_idx == AW'(NUM_SLOTS - 1)) ||
                      (due && (r_cnt == mspt_pkg::CNT_W'(mspt_pkg::MAX_OUT - 1)));
    assign new_rep  = (rd_tim.repeats != mspt_pkg::FOREVER && rd_tim.repeats != 8'd0) ?
                      rd_tim.repeats - 8'd1 : rd_tim.repeats;

    assign sid_idx   = i_req.slot_id[AW-1:0];
    assign sid_valid = (i_req.slot_id < 8'(NUM_SLOTS)) && r_active[sid_idx];

    always_comb begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                has_free = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mspt_pkg::S_IDLE: begin
                if (req_acc && i_req.req_type == mspt_pkg::REQ_POLL) begin
                    n_state = mspt_pkg::S_POLL;
                end
            end
            mspt_pkg::S_POLL: begin
                if (!ev_stall && scan_end) begin
                    n_state = mspt_pkg::S_DONE;
                end
            end
            mspt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = mspt_pkg::S_IDLE;
                end
            end
            default: n_state = mspt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_now       = r_now;
        n_active    = r_active;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        n_pend_tag  = r_pend_tag;
        n_out_vld   = r_out_vld && !o_resp.ready;
        n_out       = r_out;
        wr          = '0;
        raddr       = '0;
        unique case (r_state)
            mspt_pkg::S_IDLE: begin
                if (req_acc) begin
                    unique case (mspt_pkg::t_req_type'(i_req.req_type))
                        mspt_pkg::REQ_START: begin
                            n_out_vld = 1'b1;
                            if (has_free) begin
                                n_active[free_idx] = 1'b1;
                                wr.tim_we  = 1'b1;
                                wr.tag_we  = 1'b1;
                                wr.addr    = 8'(free_idx);
                                wr.tim     = '{start: r_now, period: i_req.period_ms,
                                               repeats: i_req.repeat_count};
                                wr.tag     = i_req.user_tag;
                                n_out      = '{kind: mspt_pkg::RESP_START, ok: 1'b1,
                                               slot: 8'(free_idx), tag: 16'd0, last: 1'b1};
                            end else begin
                                n_out      = '{kind: mspt_pkg::RESP_START, ok: 1'b0,
                                               slot: mspt_pkg::FULL_SLOT, tag: 16'd0,
                                               last: 1'b1};
                            end
                        end
                        mspt_pkg::REQ_RESTART: begin
                            n_out_vld = 1'b1;
                            if (sid_valid) begin
                                wr.tim_we = 1'b1;
                                wr.addr   = i_req.slot_id;
                                wr.tim    = '{start: r_now, period: i_req.period_ms,
                                              repeats: i_req.repeat_count};
                            end
                            n_out = '{kind: mspt_pkg::RESP_RESTART, ok: sid_valid,
                                      slot: i_req.slot_id, tag: 16'd0, last: 1'b1};
                        end
                        mspt_pkg::REQ_CANCEL: begin
                            n_out_vld = 1'b1;
                            if (sid_valid) begin
                                n_active[sid_idx] = 1'b0;
                            end
                            n_out = '{kind: mspt_pkg::RESP_CANCEL, ok: sid_valid,
                                      slot: i_req.slot_id, tag: 16'd0, last: 1'b1};
                        end
                        mspt_pkg::REQ_TICK: begin
                            n_out_vld = 1'b1;
                            n_now     = r_now + 32'd1;
                            n_out     = '{kind: mspt_pkg::RESP_TICK, ok: 1'b1,
                                          slot: 8'd0, tag: 16'd0, last: 1'b1};
                        end
                        mspt_pkg::REQ_POLL: begin
                            n_idx      = '0;
                            n_cnt      = '0;
                            n_pend_vld = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mspt_pkg::S_POLL: begin
                raddr = r_idx;
                if (!ev_stall) begin
                    if (due) begin
                        if (r_pend_vld) begin
                            n_out_vld = 1'b1;
                            n_out     = '{kind: mspt_pkg::RESP_EXPIRY, ok: 1'b1,
                                          slot: 8'(r_pend_slot), tag: r_pend_tag,
                                          last: 1'b0};
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_slot = r_idx;
                        n_pend_tag  = rd_tag;
                        wr.tim_we   = 1'b1;
                        wr.addr     = 8'(r_idx);
                        wr.tim      = '{start: r_now, period: rd_tim.period, repeats: new_rep};
                        if (new_rep == 8'd0) begin
                            n_active[r_idx] = 1'b0;
                        end
                        n_cnt = r_cnt + mspt_pkg::CNT_W'(1);
                    end
                    if (!scan_end) begin
                        n_idx = r_idx + AW'(1);
                        raddr = r_idx + AW'(1);
                    end
                end
            end
            mspt_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    if (r_pend_vld) begin
                        n_out = '{kind: mspt_pkg::RESP_EXPIRY, ok: 1'b1,
                                  slot: 8'(r_pend_slot), tag: r_pend_tag, last: 1'b1};
                    end else begin
                        n_out = '{kind: mspt_pkg::RESP_NONE, ok: 1'b1,
                                  slot: 8'd0, tag: 16'd0, last: 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mspt_pkg::S_IDLE;
            r_now      <= '0;
            r_active   <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_active   <= n_active;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_pend_slot <= n_pend_slot;
        r_pend_tag  <= n_pend_tag;
        r_out       <= n_out;
    end

    assign o_resp.valid     = r_out_vld;
    assign o_resp.resp_kind = r_out.kind;
    assign o_resp.ok        = r_out.ok;
    assign o_resp.slot_out  = r_out.slot;
    assign o_resp.tag_out   = r_out.tag;
    assign o_resp.last      = r_out.last;
endmodule

// ===== rtl/core/mspt_slot_store.sv =====
// Slot record memories: timing record and user tag, one entry per slot.
// One write port and one registered read port each. Uses mspt_pkg.
module mspt_slot_store #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                                          i_clk,
    input  mspt_pkg::t_wr_cmd                             i_wr,
    input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] i_raddr,
    output mspt_pkg::t_timing                             o_tim,
    output logic [15:0]                                   o_tag
);
    localparam int AW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

    mspt_pkg::t_timing r_tim_mem [NUM_SLOTS];
    logic [15:0]       r_tag_mem [NUM_SLOTS];
    mspt_pkg::t_timing r_tim_rd;
    logic [15:0]       r_tag_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.tim_we) begin
            r_tim_mem[i_wr.addr[AW-1:0]] <= i_wr.tim;
        end
        if (i_wr.tag_we) begin
            r_tag_mem[i_wr.addr[AW-1:0]] <= i_wr.tag;
        end
        r_tim_rd <= r_tim_mem[i_raddr];
        r_tag_rd <= r_tag_mem[i_raddr];
    end

    assign o_tim = r_tim_rd;
    assign o_tag = r_tag_rd;
endmodule

// ===== rtl/core/mspt_checker.sv =====
// Port-level checks for the multi-slot periodic timer, bound to the top level.
// Uses mspt_pkg.
module mspt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_ready,
    input logic        i_resp_valid,
    input logic        i_resp_ready,
    input logic [2:0]  i_resp_kind,
    input logic        i_resp_ok,
    input logic [7:0]  i_resp_slot,
    input logic [15:0] i_resp_tag,
    input logic        i_resp_last
);
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_resp_valid && !i_resp_ready |=> i_resp_valid && $stable(i_resp_kind) &&
        $stable(i_resp_slot) && $stable(i_resp_tag) && $stable(i_resp_last))
        else $error("response changed while stalled");

    a_only_expiry_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_resp_valid && i_resp_kind != mspt_pkg::RESP_EXPIRY |-> i_resp_last)
        else $error("non-expiry response without last");

    a_tick_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_resp_valid && i_resp_kind == mspt_pkg::RESP_TICK |->
        i_resp_ok && i_resp_slot == 8'd0 && i_resp_tag == 16'd0)
        else $error("malformed tick response");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_resp_valid && i_resp_kind == mspt_pkg::RESP_START && !i_resp_ok |->
        i_resp_slot == mspt_pkg::FULL_SLOT)
        else $error("failed start without full marker");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> !i_resp_valid || i_resp_ready)
        else $error("request taken with no room for its response");
endmodule

bind multi_slot_periodic_timer mspt_checker u_mspt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_resp_valid (o_resp.valid),
    .i_resp_ready (o_resp.ready),
    .i_resp_kind  (o_resp.resp_kind),
    .i_resp_ok    (o_resp.ok),
    .i_resp_slot  (o_resp.slot_out),
    .i_resp_tag   (o_resp.tag_out),
    .i_resp_last  (o_resp.last)
);
